// ===== rtl/core/esd_pkg.sv =====
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types, character codes and small lookup functions for the escape
// sequence decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

    // Parse modes, one-hot
    typedef enum logic [4:0] {
        MODE_TEXT = 5'b00001,
        MODE_ESC  = 5'b00010,
        MODE_HEX1 = 5'b00100,
        MODE_HEX2 = 5'b01000,
        MODE_OCT  = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        done_res;
        logic        bad_hex;
        logic [15:0] out_length;
    } result_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] acc;
        logic [1:0] oct_cnt;
        logic       err;
    } parse_state_t;

    // Up to two results produced by one input transaction
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] value;
    } lookup_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_LVL_W = 3;

    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_0         = 8'h30;
    localparam logic [7:0] CH_7         = 8'h37;
    localparam logic [7:0] CH_9         = 8'h39;
    localparam logic [7:0] CH_UA        = 8'h41;
    localparam logic [7:0] CH_UF        = 8'h46;
    localparam logic [7:0] CH_LA        = 8'h61;
    localparam logic [7:0] CH_LF        = 8'h66;

    localparam logic [7:0] CODE_ESC = 8'h1b;
    localparam logic [7:0] CODE_CR  = 8'h0d;
    localparam logic [7:0] CODE_LF  = 8'h0a;
    localparam logic [7:0] CODE_BEL = 8'h07;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_TAB = 8'h09;
    localparam logic [7:0] CODE_VT  = 8'h0b;
    localparam logic [7:0] CODE_FF  = 8'h0c;
    localparam logic [7:0] CODE_SP  = 8'h20;

    function automatic logic octal_char(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_7);
    endfunction

    // value field carries the digit in its low nibble
    function automatic lookup_t hex_value(input logic [7:0] c);
        lookup_t r;
        r.ok    = 1'b1;
        r.value = 8'h00;
        if ((c >= CH_0) && (c <= CH_9)) begin
            r.value = c - CH_0;
        end else if ((c >= CH_UA) && (c <= CH_UF)) begin
            r.value = c - CH_UA + 8'd10;
        end else if ((c >= CH_LA) && (c <= CH_LF)) begin
            r.value = c - CH_LA + 8'd10;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    // Single-character named escapes
    function automatic lookup_t named_escape(input logic [7:0] c);
        lookup_t r;
        r.ok = 1'b1;
        unique case (c)
            8'h65:        r.value = CODE_ESC;   // e
            8'h73, 8'h20: r.value = CODE_SP;    // s, space
            8'h5c, 8'h22, 8'h27, 8'h60, 8'h24: r.value = c;
            8'h72:        r.value = CODE_CR;    // r
            8'h6e:        r.value = CODE_LF;    // n
            8'h61:        r.value = CODE_BEL;   // a
            8'h62:        r.value = CODE_BS;    // b
            8'h74:        r.value = CODE_TAB;   // t
            8'h76:        r.value = CODE_VT;    // v
            8'h66:        r.value = CODE_FF;    // f
            default: begin
                r.ok    = 1'b0;
                r.value = 8'h00;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/esd_decode.sv =====
// ----------------------------------------------------------------------------
// esd_decode
// Next-state and result logic for one input byte or end marker.
// ----------------------------------------------------------------------------
module esd_decode #(
    parameter int LENGTH_BITS = 16
) (
    input  logic [7:0]             data_byte,
    input  logic                   is_end,
    input  esd_pkg::parse_state_t  state_cur,
    input  logic [LENGTH_BITS-1:0] count_cur,
    output esd_pkg::parse_state_t  state_next,
    output logic [LENGTH_BITS-1:0] count_next,
    output esd_pkg::push_t         push
);

    localparam int WIDE_W = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

    logic                   a_v, b_v, st_v;
    logic [7:0]             a_byte, b_byte;
    logic [LENGTH_BITS-1:0] count_a, count_b;
    logic [WIDE_W-1:0]      count_wide;
    logic [15:0]            len;
    logic [2:0]             oct_sum;
    esd_pkg::lookup_t       hexv, named;
    esd_pkg::result_t       res_a, res_b, res_st;
    esd_pkg::parse_state_t  st;

    always_comb begin
        hexv    = esd_pkg::hex_value(data_byte);
        named   = esd_pkg::named_escape(data_byte);
        oct_sum = {1'b0, state_cur.oct_cnt} + 3'd1;
        st      = state_cur;
        a_v     = 1'b0;
        b_v     = 1'b0;
        st_v    = 1'b0;
        a_byte  = 8'h00;
        b_byte  = data_byte;

        if (is_end) begin
            st_v = 1'b1;
            if (!state_cur.err) begin
                unique case (state_cur.mode)
                    esd_pkg::MODE_ESC: begin
                        a_v    = 1'b1;
                        a_byte = esd_pkg::CH_BACKSLASH;
                    end
                    esd_pkg::MODE_OCT: begin
                        a_v    = 1'b1;
                        a_byte = state_cur.acc;
                    end
                    esd_pkg::MODE_HEX1, esd_pkg::MODE_HEX2: st.err = 1'b1;
                    default: ;
                endcase
            end
        end else if (!state_cur.err) begin
            unique case (state_cur.mode)
                esd_pkg::MODE_ESC: begin
                    st.mode = esd_pkg::MODE_TEXT;
                    if (named.ok) begin
                        a_v    = 1'b1;
                        a_byte = named.value;
                    end else if (data_byte == esd_pkg::CH_X) begin
                        st.acc  = 8'h00;
                        st.mode = esd_pkg::MODE_HEX1;
                    end else if (esd_pkg::octal_char(data_byte)) begin
                        st.acc     = data_byte - esd_pkg::CH_0;
                        st.oct_cnt = 2'd1;
                        st.mode    = esd_pkg::MODE_OCT;
                    end else begin
                        // unknown escape keeps the backslash, then the byte
                        a_v    = 1'b1;
                        a_byte = esd_pkg::CH_BACKSLASH;
                        b_v    = 1'b1;
                    end
                end
                esd_pkg::MODE_HEX1: begin
                    if (hexv.ok) begin
                        st.acc  = hexv.value;
                        st.mode = esd_pkg::MODE_HEX2;
                    end else begin
                        st.err  = 1'b1;
                        st.mode = esd_pkg::MODE_TEXT;
                    end
                end
                esd_pkg::MODE_HEX2: begin
                    st.mode = esd_pkg::MODE_TEXT;
                    st.acc  = 8'h00;
                    if (hexv.ok) begin
                        a_v    = 1'b1;
                        a_byte = {state_cur.acc[3:0], hexv.value[3:0]};
                    end else begin
                        st.err = 1'b1;
                    end
                end
                esd_pkg::MODE_OCT: begin
                    if (esd_pkg::octal_char(data_byte)) begin
                        st.acc     = {state_cur.acc[4:0], data_byte[2:0]};
                        st.oct_cnt = oct_sum[1:0];
                        if (oct_sum >= 3'd3) begin
                            a_v        = 1'b1;
                            a_byte     = st.acc;
                            st.oct_cnt = 2'd0;
                            st.mode    = esd_pkg::MODE_TEXT;
                        end
                    end else begin
                        // run cut short: flush value; byte is plain text unless it is a backslash
                        a_v        = 1'b1;
                        a_byte     = state_cur.acc;
                        st.oct_cnt = 2'd0;
                        st.mode    = esd_pkg::MODE_TEXT;
                        if (data_byte == esd_pkg::CH_BACKSLASH) begin
                            st.mode = esd_pkg::MODE_ESC;
                        end else begin
                            b_v = 1'b1;
                        end
                    end
                end
                default: begin
                    st.mode = esd_pkg::MODE_TEXT;
                    if (data_byte == esd_pkg::CH_BACKSLASH) begin
                        st.mode = esd_pkg::MODE_ESC;
                    end else begin
                        a_v    = 1'b1;
                        a_byte = data_byte;
                    end
                end
            endcase
        end

        // saturating byte count
        count_a = count_cur;
        if (a_v && (count_cur != '1)) begin
            count_a = count_cur + 1'b1;
        end
        count_b = count_a;
        if (b_v && (count_a != '1)) begin
            count_b = count_a + 1'b1;
        end

        count_wide = WIDE_W'(count_b);
        if (count_wide > WIDE_W'(17'hFFFF)) begin
            len = 16'hFFFF;
        end else begin
            len = count_wide[15:0];
        end
        if (st.err) begin
            len = 16'h0000;
        end

        res_a  = '{out_byte: a_byte, byte_valid: 1'b1, done_res: 1'b0,
                   bad_hex: 1'b0, out_length: 16'h0000};
        res_b  = '{out_byte: b_byte, byte_valid: 1'b1, done_res: 1'b0,
                   bad_hex: 1'b0, out_length: 16'h0000};
        res_st = '{out_byte: 8'h00, byte_valid: 1'b0, done_res: 1'b1,
                   bad_hex: st.err, out_length: len};

        push.first  = res_st;
        push.second = res_st;
        push.count  = 2'd0;
        if (a_v) begin
            push.first = res_a;
            if (b_v) begin
                push.second = res_b;
                push.count  = 2'd2;
            end else if (st_v) begin
                push.count = 2'd2;
            end else begin
                push.count = 2'd1;
            end
        end else if (st_v) begin
            push.count = 2'd1;
        end

        if (is_end) begin
            state_next = '{mode: esd_pkg::MODE_TEXT, acc: 8'h00, oct_cnt: 2'd0,
                           err: 1'b0};
            count_next = '0;
        end else begin
            state_next = st;
            count_next = count_b;
        end
    end

endmodule

// ===== rtl/core/esd_result_queue.sv =====
// ----------------------------------------------------------------------------
// esd_result_queue
// Small result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module esd_result_queue (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              push_en,
    input  esd_pkg::push_t                    push,
    input  logic                              pop,
    output logic                              not_empty,
    output logic                              room_for_two,
    output logic [esd_pkg::QUEUE_LVL_W-1:0]   level,
    output esd_pkg::result_t                  head_data
);

    esd_pkg::result_t                  mem_reg [esd_pkg::QUEUE_DEPTH];
    logic [esd_pkg::QUEUE_PTR_W-1:0]   head_reg, head_next;
    logic [esd_pkg::QUEUE_LVL_W-1:0]   level_reg, level_next;
    logic [esd_pkg::QUEUE_PTR_W-1:0]   tail0, tail1;
    logic [1:0]                        n_push;

    assign n_push       = push_en ? push.count : 2'd0;
    assign tail0        = head_reg + level_reg[esd_pkg::QUEUE_PTR_W-1:0];
    assign tail1        = tail0 + 1'b1;
    assign not_empty    = (level_reg != '0);
    assign room_for_two = (level_reg <= esd_pkg::QUEUE_LVL_W'(esd_pkg::QUEUE_DEPTH - 2));
    assign level        = level_reg;
    assign head_data    = mem_reg[head_reg];

    always_comb begin
        head_next  = head_reg + (pop ? 1'b1 : 1'b0);
        level_next = level_reg + esd_pkg::QUEUE_LVL_W'(n_push)
                     - (pop ? 1'b1 : 1'b0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            level_reg <= '0;
        end else begin
            head_reg  <= head_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            mem_reg[tail0] <= push.first;
        end
        if (n_push == 2'd2) begin
            mem_reg[tail1] <= push.second;
        end
    end

endmodule

// ===== rtl/core/escape_sequence_decoder.sv =====
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// Unescapes a C-style byte string one byte per transaction and reports the
// decoded length on an end marker.
// ----------------------------------------------------------------------------
//
//  channel | direction | payload                                       | handshake
//  --------+-----------+-----------------------------------------------+------------------
//  s_      | in        | data_byte[7:0], is_end                        | s_valid / s_ready
//  m_      | out       | out_byte[7:0], byte_valid, done_res, bad_hex, | m_valid / m_ready
//          |           | out_length[15:0]                              |
//
//  One input transaction is taken per cycle while the four-entry result queue
//  has room for two; with one result per input and m_ready high the block
//  sustains one byte per cycle. Each result is written into the queue before it reaches m_.
//  An input yields zero, one or two results; the queue drains one per cycle on m_ready.
//  Reset (aresetn low, synchronous) empties the queue and clears the parser.
//  A stall on m_ fills the queue, which then drops s_ready.
//
module escape_sequence_decoder #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_is_end,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_valid,
    output logic        m_done_res,
    output logic        m_bad_hex,
    output logic [15:0] m_out_length
);

    // parser state, updated on every accepted transaction
    esd_pkg::parse_state_t            state_reg, state_next;
    logic [LENGTH_BITS-1:0]           count_reg, count_next;

    esd_pkg::push_t                   push;
    esd_pkg::result_t                 head_data;
    logic                             s_accept;
    logic                             m_accept;
    logic                             room_for_two;
    logic [esd_pkg::QUEUE_LVL_W-1:0]  level;

    assign s_ready  = room_for_two;
    assign s_accept = s_valid && s_ready;
    assign m_accept = m_valid && m_ready;

    esd_decode #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_decode (
        .data_byte  (s_data_byte),
        .is_end     (s_is_end),
        .state_cur  (state_reg),
        .count_cur  (count_reg),
        .state_next (state_next),
        .count_next (count_next),
        .push       (push)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{mode: esd_pkg::MODE_TEXT, acc: 8'h00, oct_cnt: 2'd0,
                           err: 1'b0};
            count_reg <= '0;
        end else if (s_accept) begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // results wait here; the output side stalls independently of the input
    esd_result_queue u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push_en      (s_accept),
        .push         (push),
        .pop          (m_accept),
        .not_empty    (m_valid),
        .room_for_two (room_for_two),
        .level        (level),
        .head_data    (head_data)
    );

    assign m_out_byte   = head_data.out_byte;
    assign m_byte_valid = head_data.byte_valid;
    assign m_done_res   = head_data.done_res;
    assign m_bad_hex    = head_data.bad_hex;
    assign m_out_length = head_data.out_length;

    // queue never overfills
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level <= esd_pkg::QUEUE_LVL_W'(esd_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    // an end marker leaves the parser in its reset state
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_is_end) |=>
            (state_reg.mode == esd_pkg::MODE_TEXT) && !state_reg.err
            && (count_reg == '0) && (state_reg.acc == 8'h00))
        else $error("state not cleared after end transaction");

    // after a hex error, data bytes produce nothing
    a_error_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && state_reg.err && !s_is_end) |=>
            (level <= $past(level)) && state_reg.err)
        else $error("output produced after hex error");

endmodule
